FILE: hdl/pfio_pkg.sv
// Shared types and codes for the modular inverse and order unit.
package pfio_pkg;

    localparam logic [1:0] OP_RECIP  = 2'd0;
    localparam logic [1:0] OP_MORD   = 2'd1;
    localparam logic [1:0] OP_AORD   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_ZERO  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EU_TEST,
        ST_EU_DIV,
        ST_EU_MUL,
        ST_EU_UPD,
        ST_ADD_DIV,
        ST_ORD_TEST,
        ST_ORD_MUL,
        ST_ORD_START,
        ST_ORD_DIV
    } state_t;

    typedef enum logic [1:0] {
        DIV_EUCLID,
        DIV_ADD,
        DIV_MUL
    } div_sel_t;

    typedef enum logic [2:0] {
        RES_ERR_ZERO,
        RES_ERR_RANGE,
        RES_INV,
        RES_ADD,
        RES_ORD
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     euclid_mul;
        logic     euclid_upd;
        logic     mul_prep;
        logic     mul_upd;
        logic     set_result;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       div_done;
        logic       r1_zero;
        logic       r0_one;
        logic       a_zero;
        logic       a_ge_m;
        logic       x_one;
        logic       n_gt_m;
    } dp_stat_t;

endpackage

FILE: hdl/pfio_div.sv
// Restoring divider that produces one quotient bit per cycle.
module pfio_div
    import pfio_pkg::*;
#(
    parameter int WORD_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [2*WORD_BITS-1:0] dividend,
    input  logic [WORD_BITS-1:0]   divisor,
    output logic                   done,
    output logic [2*WORD_BITS-1:0] quotient,
    output logic [WORD_BITS-1:0]   remainder
);

    localparam int STEPS = 2 * WORD_BITS;
    localparam int CW    = $clog2(STEPS + 1);

    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   done_reg;
    logic [2*WORD_BITS-1:0] dvd_reg, dvd_next;
    logic [WORD_BITS-1:0]   dvs_reg, dvs_next;
    logic [WORD_BITS-1:0]   rem_reg, rem_next;
    logic [WORD_BITS:0]     tmp;
    logic [WORD_BITS:0]     diff;
    logic                   ge;

    always_comb
    begin
        tmp      = {rem_reg, dvd_reg[2*WORD_BITS-1]};
        ge       = tmp >= {1'b0, dvs_reg};
        diff     = tmp - {1'b0, dvs_reg};
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        dvs_next = dvs_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = CW'(STEPS);
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CW'(1);
            dvd_next = {dvd_reg[2*WORD_BITS-2:0], ge};
            rem_next = ge ? diff[WORD_BITS-1:0] : tmp[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= !start && (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/pfio_dp.sv
// Datapath with Euclid, order and result registers around the shared divider.
module pfio_dp
    import pfio_pkg::*;
#(
    parameter int WORD_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    input  logic [1:0]           operation,
    input  logic [WORD_BITS-1:0] operand,
    input  logic [WORD_BITS-1:0] modulus,
    output dp_stat_t             stat,
    output logic [WORD_BITS-1:0] value,
    output logic [1:0]           error,
    output logic                 done
);

    localparam int TW = WORD_BITS + 2;

    logic [1:0]             op_reg;
    logic [WORD_BITS-1:0]   a_reg;
    logic [WORD_BITS-1:0]   r0_reg;
    logic [WORD_BITS-1:0]   r1_reg;
    logic signed [TW-1:0]   t0_reg;
    logic signed [TW-1:0]   t1_reg;
    logic signed [TW-1:0]   qt_reg;
    logic [2*WORD_BITS-1:0] prod_reg;
    logic [WORD_BITS-1:0]   x_reg;
    logic [WORD_BITS:0]     n_reg;
    logic [WORD_BITS-1:0]   value_reg, value_next;
    logic [1:0]             error_reg, error_next;
    logic                   done_reg;

    logic [2*WORD_BITS-1:0] div_dividend;
    logic [WORD_BITS-1:0]   div_divisor;
    logic                   div_done;
    logic [2*WORD_BITS-1:0] div_q;
    logic [WORD_BITS-1:0]   div_r;
    logic signed [TW-1:0]   q_s;
    logic signed [2*TW-1:0] qt_full;
    logic signed [TW-1:0]   inv_sum;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_EUCLID:
            begin
                div_dividend = {{WORD_BITS{1'b0}}, r0_reg};
                div_divisor  = r1_reg;
            end
            DIV_ADD:
            begin
                div_dividend = {{WORD_BITS{1'b0}}, modulus};
                div_divisor  = r0_reg;
            end
            DIV_MUL:
            begin
                div_dividend = prod_reg;
                div_divisor  = modulus;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = modulus;
            end
        endcase
    end

    pfio_div #(
        .WORD_BITS(WORD_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign q_s     = {2'b00, div_q[WORD_BITS-1:0]};
    assign qt_full = q_s * t1_reg;
    assign inv_sum = t0_reg[TW-1] ? (t0_reg + $signed({2'b00, modulus})) : t0_reg;

    always_comb
    begin
        value_next = value_reg;
        error_next = error_reg;
        case (cmd.res_sel)
            RES_ERR_ZERO:
            begin
                value_next = '0;
                error_next = ERR_ZERO;
            end
            RES_ERR_RANGE:
            begin
                value_next = '0;
                error_next = ERR_RANGE;
            end
            RES_INV:
            begin
                value_next = inv_sum[WORD_BITS-1:0];
                error_next = ERR_NONE;
            end
            RES_ADD:
            begin
                value_next = div_q[WORD_BITS-1:0];
                error_next = ERR_NONE;
            end
            RES_ORD:
            begin
                value_next = n_reg[WORD_BITS-1:0];
                error_next = ERR_NONE;
            end
            default:
            begin
                value_next = '0;
                error_next = ERR_RANGE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= operation;
            a_reg  <= operand;
            r0_reg <= modulus;
            r1_reg <= operand;
            t0_reg <= '0;
            t1_reg <= TW'(1);
            x_reg  <= operand;
            n_reg  <= (WORD_BITS + 1)'(1);
        end
        if (cmd.euclid_mul)
        begin
            qt_reg <= qt_full[TW-1:0];
        end
        if (cmd.euclid_upd)
        begin
            r0_reg <= r1_reg;
            r1_reg <= div_r;
            t0_reg <= t1_reg;
            t1_reg <= t0_reg - qt_reg;
        end
        if (cmd.mul_prep)
        begin
            prod_reg <= x_reg * a_reg;
        end
        if (cmd.mul_upd)
        begin
            x_reg <= div_r;
            n_reg <= n_reg + (WORD_BITS + 1)'(1);
        end
        if (cmd.set_result)
        begin
            value_reg <= value_next;
            error_reg <= error_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.set_result;
        end
    end

    always_comb
    begin
        stat.op       = op_reg;
        stat.div_done = div_done;
        stat.r1_zero  = r1_reg == '0;
        stat.r0_one   = r0_reg == WORD_BITS'(1);
        stat.a_zero   = a_reg == '0;
        stat.a_ge_m   = a_reg >= modulus;
        stat.x_one    = x_reg == WORD_BITS'(1);
        stat.n_gt_m   = n_reg > {1'b0, modulus};
    end

    assign value = value_reg;
    assign error = error_reg;
    assign done  = done_reg;

endmodule

FILE: hdl/pfio_ctrl.sv
// Controller state machine that sequences checks, Euclid steps and order steps.
module pfio_ctrl
    import pfio_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.op == OP_UNUSED)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_sel    = RES_ERR_RANGE;
                    state_next     = ST_IDLE;
                end
                else if (stat.op != OP_AORD && stat.a_zero)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_sel    = RES_ERR_ZERO;
                    state_next     = ST_IDLE;
                end
                else if (stat.a_ge_m)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_sel    = RES_ERR_RANGE;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EU_TEST;
                end
            end
            ST_EU_TEST:
            begin
                if (!stat.r1_zero)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_EUCLID;
                    state_next    = ST_EU_DIV;
                end
                else if (stat.op == OP_AORD)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_ADD;
                    state_next    = ST_ADD_DIV;
                end
                else if (!stat.r0_one)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_sel    = RES_ERR_RANGE;
                    state_next     = ST_IDLE;
                end
                else if (stat.op == OP_RECIP)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_sel    = RES_INV;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ORD_TEST;
                end
            end
            ST_EU_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_EU_MUL;
                end
            end
            ST_EU_MUL:
            begin
                cmd.euclid_mul = 1'b1;
                state_next     = ST_EU_UPD;
            end
            ST_EU_UPD:
            begin
                cmd.euclid_upd = 1'b1;
                state_next     = ST_EU_TEST;
            end
            ST_ADD_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_sel    = RES_ADD;
                    state_next     = ST_IDLE;
                end
            end
            ST_ORD_TEST:
            begin
                if (stat.x_one || stat.n_gt_m)
                begin
                    cmd.set_result = 1'b1;
                    cmd.res_sel    = RES_ORD;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ORD_MUL;
                end
            end
            ST_ORD_MUL:
            begin
                cmd.mul_prep = 1'b1;
                state_next   = ST_ORD_START;
            end
            ST_ORD_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MUL;
                state_next    = ST_ORD_DIV;
            end
            ST_ORD_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.mul_upd = 1'b1;
                    state_next  = ST_ORD_TEST;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = state_reg != ST_IDLE;

endmodule

FILE: hdl/prime_field_inverse_and_order_top.sv
// Top level: one transaction at a time; the shared restoring divider (one bit a cycle) sets speed.
// Reciprocal and additive order finish in a few Euclid steps, at most 23 at 16 bits.
// Multiplicative order adds multiply-reduce steps, up to modulus-2 of them.
// The result shows for one cycle on done, in the cycle after the final state decides it; it cannot be stalled.
// Reset is asynchronous and active low; it returns the controller to idle and the modulus to 2.
module prime_field_inverse_and_order_top
    import pfio_pkg::*;
#(
    parameter int WORD_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           operation,
    input  logic [WORD_BITS-1:0] operand,
    output logic                 done,
    output logic [WORD_BITS-1:0] value,
    output logic [1:0]           error,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [WORD_BITS-1:0] modulus
);

    logic [WORD_BITS-1:0] modulus_reg;
    dp_cmd_t              cmd;
    dp_stat_t             stat;

    assign cfg_ready = !busy && !start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= WORD_BITS'(2);
        end
        else if (cfg_valid && cfg_ready)
        begin
            modulus_reg <= modulus;
        end
    end

    pfio_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    pfio_dp #(
        .WORD_BITS(WORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .operation (operation),
        .operand   (operand),
        .modulus   (modulus_reg),
        .stat      (stat),
        .value     (value),
        .error     (error),
        .done      (done)
    );

endmodule

FILE: dv/tb_prime_field_inverse_and_order_top.sv
// Testbench for the modular inverse and order unit: directed and random checks against a predictor.
`timescale 1ns / 100ps

module tb_prime_field_inverse_and_order_top;
    import pfio_pkg::*;

    localparam int WORD_BITS = 16;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int ORDER_CAP = 300;

    typedef struct packed {
        logic [WORD_BITS-1:0] value;
        logic [1:0]           err;
    } ring_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           operation;
    logic [WORD_BITS-1:0] operand;
    logic                 done;
    logic [WORD_BITS-1:0] value;
    logic [1:0]           error;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [WORD_BITS-1:0] cfg_modulus;

    ring_result_t         pending_results[$];
    logic [WORD_BITS-1:0] model_modulus;
    int unsigned          gap_pct;
    int unsigned          fail_count;
    int unsigned          cycle_count;

    prime_field_inverse_and_order_top #(.WORD_BITS(WORD_BITS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .operand   (operand),
        .done      (done),
        .value     (value),
        .error     (error),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .modulus   (cfg_modulus)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic longint unsigned ring_gcd(input longint unsigned a, input longint unsigned b);
        longint unsigned t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic ring_result_t predict_ring_op(input logic [1:0] op,
                                                     input logic [WORD_BITS-1:0] a_in,
                                                     input logic [WORD_BITS-1:0] m_in);
        ring_result_t res;
        longint a;
        longint m;
        longint r0, r1, t0, t1, q, rn, tn;
        longint x, n;
        a = a_in;
        m = m_in;
        res.value = '0;
        res.err = ERR_NONE;
        if (op == OP_UNUSED)
            res.err = ERR_RANGE;
        else if (op != OP_AORD && a == 0)
            res.err = ERR_ZERO;
        else if (a >= m)
            res.err = ERR_RANGE;
        else if (op == OP_AORD)
            res.value = WORD_BITS'(m / longint'(ring_gcd(a, m)));
        else if (ring_gcd(a, m) != 1)
            res.err = ERR_RANGE;
        else if (op == OP_RECIP)
        begin
            r0 = m;
            r1 = a;
            t0 = 0;
            t1 = 1;
            while (r1 != 0)
            begin
                q = r0 / r1;
                rn = r0 - q * r1;
                tn = t0 - q * t1;
                r0 = r1;
                r1 = rn;
                t0 = t1;
                t1 = tn;
            end
            if (r0 != 1)
                res.err = ERR_RANGE;
            else
            begin
                if (t0 < 0)
                    t0 += m;
                res.value = WORD_BITS'(t0);
            end
        end
        else
        begin
            x = a;
            n = 1;
            while (x != 1 && n <= m)
            begin
                x = (x * a) % m;
                n++;
            end
            res.value = WORD_BITS'(n);
        end
        return res;
    endfunction

    always @(posedge clk)
    begin
        ring_result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result value=%0d error=%0d", value, error));
            else
            begin
                exp_res = pending_results.pop_front();
                if (value !== exp_res.value)
                    report_mismatch($sformatf("value %0d, expected %0d", value, exp_res.value));
                if (error !== exp_res.err)
                    report_mismatch($sformatf("error %0d, expected %0d", error, exp_res.err));
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [WORD_BITS-1:0] a);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
            @(negedge clk);
        while (busy)
            @(negedge clk);
        start <= 1'b1;
        operation <= op;
        operand <= a;
        @(posedge clk);
        pending_results.push_back(predict_ring_op(op, a, model_modulus));
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
        while (busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_modulus(input logic [WORD_BITS-1:0] m);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_modulus <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        model_modulus = m;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_modulus();
        send_item(OP_RECIP, 16'd1);
        send_item(OP_MORD, 16'd1);
        send_item(OP_AORD, 16'd0);
        send_item(OP_AORD, 16'd1);
        send_item(OP_RECIP, 16'd0);
        send_item(OP_MORD, 16'd2);
        send_item(OP_UNUSED, 16'd1);
    endtask

    task automatic test_field_extremes();
        write_modulus(16'd65535);
        send_item(OP_RECIP, 16'd65534);
        send_item(OP_RECIP, 16'd3);
        send_item(OP_AORD, 16'd65534);
        send_item(OP_AORD, 16'd257);
        send_item(OP_MORD, 16'd2);
        send_item(OP_MORD, 16'd0);
        send_item(OP_AORD, 16'd65535);
        send_item(OP_UNUSED, 16'd0);
        write_modulus(16'd65521);
        send_item(OP_RECIP, 16'd65520);
        send_item(OP_RECIP, 16'd12345);
        send_item(OP_MORD, 16'd65520);
        send_item(OP_AORD, 16'd12345);
    endtask

    task automatic test_composite_modulus();
        write_modulus(16'd7);
        send_item(OP_MORD, 16'd3);
        send_item(OP_RECIP, 16'd3);
        write_modulus(16'd12);
        send_item(OP_RECIP, 16'd5);
        send_item(OP_MORD, 16'd5);
        send_item(OP_RECIP, 16'd4);
        send_item(OP_AORD, 16'd8);
    endtask

    function automatic logic [WORD_BITS-1:0] pick_modulus();
        int unsigned sel;
        int unsigned primes[8] = '{3, 5, 11, 13, 31, 61, 97, 127};
        int unsigned extremes[5] = '{2, 3, 65521, 65534, 65535};
        sel = $urandom_range(99);
        if (sel < 50)
            return WORD_BITS'($urandom_range(200, 2));
        else if (sel < 70)
            return WORD_BITS'(primes[$urandom_range(7)]);
        else if (sel < 85)
            return WORD_BITS'($urandom_range(65535, 32768));
        else
            return WORD_BITS'(extremes[$urandom_range(4)]);
    endfunction

    function automatic logic [WORD_BITS-1:0] pick_operand(input logic [WORD_BITS-1:0] m);
        int unsigned sel;
        int unsigned hi;
        sel = $urandom_range(99);
        if (sel < 45)
            return WORD_BITS'($urandom_range(m - 1, 0));
        else if (sel < 55)
            return '0;
        else if (sel < 65)
            return m - 1'b1;
        else if (sel < 75)
            return WORD_BITS'(1);
        else if (sel < 90)
            return WORD_BITS'($urandom);
        else
        begin
            hi = (m > 65532) ? 65535 : m + 3;
            return WORD_BITS'($urandom_range(hi, m));
        end
    endfunction

    task automatic test_random_phase(input int unsigned gap, input int unsigned settings,
                                     input int unsigned per_setting);
        logic [1:0]           op;
        logic [WORD_BITS-1:0] a;
        ring_result_t         guess;
        gap_pct = gap;
        repeat (settings)
        begin
            write_modulus(pick_modulus());
            repeat (per_setting)
            begin
                op = ($urandom_range(9) == 0) ? OP_UNUSED : 2'($urandom_range(2));
                a = pick_operand(model_modulus);
                if (op == OP_MORD)
                begin
                    guess = predict_ring_op(op, a, model_modulus);
                    if (guess.err == ERR_NONE && guess.value > ORDER_CAP)
                        a = model_modulus - 1'b1;
                end
                send_item(op, a);
            end
        end
    endtask

    task automatic test_drain_and_resume();
        gap_pct = 0;
        write_modulus(16'd97);
        send_item(OP_RECIP, 16'd45);
        send_item(OP_MORD, 16'd96);
        wait_drained();
        send_item(OP_AORD, 16'd48);
        send_item(OP_MORD, 16'd5);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        operation = '0;
        operand = '0;
        cfg_valid = 1'b0;
        cfg_modulus = '0;
        model_modulus = WORD_BITS'(2);
        gap_pct = 0;
        fail_count = 0;
        cycle_count = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_modulus();
        test_field_extremes();
        test_composite_modulus();
        test_random_phase(0, 5, 5);
        test_random_phase(71, 5, 5);
        test_random_phase(19, 5, 5);
        test_drain_and_resume();

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (pending_results.size() != 0)
            report_mismatch("expected results left over");

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
hdl/pfio_pkg.sv
hdl/pfio_div.sv
hdl/pfio_dp.sv
hdl/pfio_ctrl.sv
hdl/prime_field_inverse_and_order_top.sv
dv/tb_prime_field_inverse_and_order_top.sv
